FILE: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned OCC_W  = 7;

    // Operation codes; codes above MODE_POP_BACK act as MODE_NONE
    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic                     error;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } result_t;

endpackage

FILE: hw/rtl/deq_ram.sv
module deq_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [deq_pkg::WORD_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic signed [deq_pkg::WORD_W-1:0] rd_data
);

    logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Bounded deque of signed 32-bit words held in a ring of CAPACITY slots.
// done strobes in the cycle after acceptance for push, no-op and error; a pop passes ST_POP first.
// Push, no-op and error transactions leave busy low; a successful pop holds busy high in ST_POP,
// because the new front or back word comes from the slot RAM's registered read.
// Reset clears the count and indices; slot contents stay undefined until written.
// done is a one-cycle strobe: the receiver cannot stall, so results are never held back.
module double_ended_queue #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::request_t request,
    output logic              done,
    output deq_pkg::result_t  result
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                            state_reg,     state_next;
    logic [CNT_W-1:0]                  cnt_reg,       cnt_next;
    logic [IDX_W-1:0]                  front_idx_reg, front_idx_next;
    logic [IDX_W-1:0]                  back_idx_reg,  back_idx_next;
    logic signed [deq_pkg::WORD_W-1:0] front_val_reg, front_val_next;
    logic signed [deq_pkg::WORD_W-1:0] back_val_reg,  back_val_next;
    logic signed [deq_pkg::WORD_W-1:0] popped_reg,    popped_next;
    logic                              pop_back_reg,  pop_back_next;
    logic                              done_reg,      done_next;
    deq_pkg::result_t                  res_reg,       res_next;

    logic                              accept;
    logic                              is_empty_now;
    logic                              is_full_now;
    logic [IDX_W-1:0]                  front_inc;
    logic [IDX_W-1:0]                  front_dec;
    logic [IDX_W-1:0]                  back_inc;
    logic [IDX_W-1:0]                  back_dec;

    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    logic                              rd_en;
    logic [IDX_W-1:0]                  rd_addr;
    logic signed [deq_pkg::WORD_W-1:0] rd_data;

    // Build one result transaction; zero the end values when the deque is empty.
    function automatic deq_pkg::result_t pack_result(
        input logic signed [deq_pkg::WORD_W-1:0] popped,
        input logic                              err,
        input logic signed [deq_pkg::WORD_W-1:0] fval,
        input logic signed [deq_pkg::WORD_W-1:0] bval,
        input logic [CNT_W-1:0]                  cnt
    );
        deq_pkg::result_t          r;
        logic [CNT_W+deq_pkg::OCC_W-1:0] occ_wide;
        logic                      empty;
        occ_wide       = {{deq_pkg::OCC_W{1'b0}}, cnt};
        empty          = (cnt == '0);
        r.popped_value = popped;
        r.error        = err;
        r.front_value  = empty ? '0 : fval;
        r.back_value   = empty ? '0 : bval;
        r.occupancy    = occ_wide[deq_pkg::OCC_W-1:0];
        r.is_empty     = empty;
        r.is_full      = (cnt == CNT_FULL);
        return r;
    endfunction

    assign busy   = (state_reg == ST_POP);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = res_reg;

    assign is_empty_now = (cnt_reg == '0);
    assign is_full_now  = (cnt_reg == CNT_FULL);

    // Ring index steps; wrap by compare so any CAPACITY works
    assign front_inc = (front_idx_reg == IDX_LAST) ? '0 : front_idx_reg + IDX_W'(1);
    assign front_dec = (front_idx_reg == '0) ? IDX_LAST : front_idx_reg - IDX_W'(1);
    assign back_inc  = (back_idx_reg == IDX_LAST) ? '0 : back_idx_reg + IDX_W'(1);
    assign back_dec  = (back_idx_reg == '0) ? IDX_LAST : back_idx_reg - IDX_W'(1);

    // A pop fetches the neighbor of the slot it removes: it becomes the new end word
    assign rd_en   = accept;
    assign rd_addr = (request.mode == deq_pkg::MODE_POP_BACK) ? back_dec : front_inc;

    deq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (request.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        front_idx_next = front_idx_reg;
        back_idx_next  = back_idx_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        popped_next    = popped_reg;
        pop_back_next  = pop_back_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = front_dec;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (request.mode)
                        deq_pkg::MODE_PUSH_FRONT:
                        begin
                            if (is_full_now)
                            begin
                                res_next = pack_result('0, 1'b1, front_val_reg,
                                                       back_val_reg, cnt_reg);
                            end
                            else
                            begin
                                // Write ahead of the front; an empty deque's back is the same word
                                wr_en          = 1'b1;
                                wr_addr        = front_dec;
                                front_idx_next = front_dec;
                                cnt_next       = cnt_reg + CNT_W'(1);
                                front_val_next = request.push_value;
                                if (is_empty_now)
                                begin
                                    back_val_next = request.push_value;
                                end
                                res_next = pack_result('0, 1'b0, request.push_value,
                                    is_empty_now ? request.push_value : back_val_reg,
                                    cnt_reg + CNT_W'(1));
                            end
                        end
                        deq_pkg::MODE_PUSH_BACK:
                        begin
                            if (is_full_now)
                            begin
                                res_next = pack_result('0, 1'b1, front_val_reg,
                                                       back_val_reg, cnt_reg);
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = back_inc;
                                back_idx_next = back_inc;
                                cnt_next      = cnt_reg + CNT_W'(1);
                                back_val_next = request.push_value;
                                if (is_empty_now)
                                begin
                                    front_val_next = request.push_value;
                                end
                                res_next = pack_result('0, 1'b0,
                                    is_empty_now ? request.push_value : front_val_reg,
                                    request.push_value, cnt_reg + CNT_W'(1));
                            end
                        end
                        deq_pkg::MODE_POP_FRONT,
                        deq_pkg::MODE_POP_BACK:
                        begin
                            if (is_empty_now)
                            begin
                                res_next = pack_result('0, 1'b1, front_val_reg,
                                                       back_val_reg, cnt_reg);
                            end
                            else
                            begin
                                // Retire the end word now; hold the result until the read returns
                                done_next     = 1'b0;
                                state_next    = ST_POP;
                                cnt_next      = cnt_reg - CNT_W'(1);
                                pop_back_next = (request.mode == deq_pkg::MODE_POP_BACK);
                                if (request.mode == deq_pkg::MODE_POP_BACK)
                                begin
                                    popped_next   = back_val_reg;
                                    back_idx_next = back_dec;
                                end
                                else
                                begin
                                    popped_next    = front_val_reg;
                                    front_idx_next = front_inc;
                                end
                            end
                        end
                        default:
                        begin
                            res_next = pack_result('0, 1'b0, front_val_reg,
                                                   back_val_reg, cnt_reg);
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // Advance the vacated end to the word just read
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (pop_back_reg)
                begin
                    back_val_next = rd_data;
                    res_next = pack_result(popped_reg, 1'b0, front_val_reg, rd_data, cnt_reg);
                end
                else
                begin
                    front_val_next = rd_data;
                    res_next = pack_result(popped_reg, 1'b0, rd_data, back_val_reg, cnt_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            front_idx_reg <= '0;
            back_idx_reg  <= IDX_LAST;
            done_reg      <= 1'b0;
            pop_back_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            done_reg      <= done_next;
            pop_back_reg  <= pop_back_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        popped_reg    <= popped_next;
        res_reg       <= res_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("element count above capacity");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (done_reg && state_reg == ST_IDLE))
        else $error("pending pop did not complete");

    a_no_write_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> !wr_en)
        else $error("slot write while a pop read is pending");

    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || state_reg == ST_POP))
        else $error("accepted transaction produced neither result nor pending pop");

    a_ring_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (back_idx_reg == ((front_idx_reg == '0) ? IDX_LAST
                                              : front_idx_reg - IDX_W'(1))))
        else $error("back index not adjacent to front on empty deque");

endmodule
